>>> rtl/bthin_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthin_pkg
// Shared types and constants of the binary image thinning core.
// ----------------------------------------------------------------------------
package bthin_pkg;

  // request kinds carried on in_tuser
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_RUN  = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [8:0]  SIZE_RESET      = 9'd256;
  localparam logic [8:0]  SIZE_MIN        = 9'd4;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
  localparam logic [7:0]  PIXEL_FG        = 8'd255;
  localparam logic [7:0]  PIXEL_BG        = 8'd0;
  localparam logic [15:0] PASS_MAX        = 16'hFFFF;
  localparam logic [3:0]  NB_MIN          = 4'd2;
  localparam logic [3:0]  NB_MAX          = 4'd6;
  localparam logic [3:0]  NB_LAST         = 4'd8;

  // sequencer states
  typedef enum logic [8:0] {
    ST_IDLE      = 9'b000000001,
    ST_RD_WAIT   = 9'b000000010,
    ST_MARK      = 9'b000000100,
    ST_MARK_WAIT = 9'b000001000,
    ST_MARK_EVAL = 9'b000010000,
    ST_CLR       = 9'b000100000,
    ST_CLR_WAIT  = 9'b001000000,
    ST_PAIR_END  = 9'b010000000,
    ST_DONE      = 9'b100000000
  } state_t;

endpackage

>>> rtl/bthin_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthin_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bthin_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/bthin_rule.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bthin_rule
// 3x3 Zhang-Suen deletion test for one pixel and its eight neighbours.
// ----------------------------------------------------------------------------
module bthin_rule
  import bthin_pkg::*;
(
  input  logic       center,
  input  logic [7:0] nb,      // n, ne, e, se, s, sw, w, nw from bit 0 up
  input  logic       phase,
  output logic       mark
);

  logic [3:0] trans;
  logic [3:0] count;
  logic       m1;
  logic       m2;

  // transitions 0->1 around the ring and neighbour count
  always_comb begin
    trans = '0;
    count = '0;
    for (int k = 0; k < 8; k++) begin
      count = count + {3'd0, nb[k]};
      if (!nb[k] && nb[(k + 1) % 8]) begin
        trans = trans + 4'd1;
      end
    end
  end

  // sub-pass dependent neighbour triples
  always_comb begin
    if (!phase) begin
      m1 = nb[0] & nb[2] & nb[4];
      m2 = nb[2] & nb[4] & nb[6];
    end else begin
      m1 = nb[0] & nb[2] & nb[6];
      m2 = nb[0] & nb[4] & nb[6];
    end
  end

  assign mark = center && (trans == 4'd1) && (count >= NB_MIN) && (count <= NB_MAX)
                && !m1 && !m2;

endmodule

>>> rtl/binary_image_thinning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_thinning_core
// Zhang-Suen thinning of a thresholded image held in on-chip bit memories.
// ----------------------------------------------------------------------------
// Load and unknown requests answer in the cycle after acceptance; reads pass
// through ST_RD_WAIT before the answer is registered. A run walks the image
// with one shared 3x3 rule unit fed by a single image read port: for each
// interior pixel it gathers the nine bits one read at a time (ST_MARK, ST_MARK_WAIT)
// and marks it in ST_MARK_EVAL, and a clearing sweep through the marker memory
// then visits each interior pixel again (ST_CLR, ST_CLR_WAIT). A run repeats pass
// pairs until one clears nothing. The block takes no request during a run.
// ----------------------------------------------------------------------------
module binary_image_thinning_core
  import bthin_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // row[7:0], col[15:8], pixel_in[23:16]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_out[7:0], pass_count[23:8]
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW    = $clog2(MAXD + 1);
  localparam int SW    = (DW > 9) ? DW : 9;

  // configuration registers
  logic [8:0] width_r;
  logic [8:0] height_r;
  logic [7:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_RESET;
      height_r <= SIZE_RESET;
      thresh_r <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: height_r <= cfg_data;
        CFG_THRESHOLD:    thresh_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // size in use, saturated to the legal range
  logic [SW-1:0] w_sat;
  logic [SW-1:0] h_sat;

  always_comb begin
    if (SW'(width_r) < SW'(SIZE_MIN))              w_sat = SW'(SIZE_MIN);
    else if (SW'(width_r) > SW'(MAX_WIDTH))        w_sat = SW'(MAX_WIDTH);
    else                                           w_sat = SW'(width_r);
    if (SW'(height_r) < SW'(SIZE_MIN))             h_sat = SW'(SIZE_MIN);
    else if (SW'(height_r) > SW'(MAX_HEIGHT))      h_sat = SW'(MAX_HEIGHT);
    else                                           h_sat = SW'(height_r);
  end

  // request fields
  logic [7:0] req_row;
  logic [7:0] req_col;
  logic [7:0] req_pix;
  logic       req_inside;
  logic [AW-1:0] req_addr;
  logic       in_acc;

  assign req_row    = in_tdata[7:0];
  assign req_col    = in_tdata[15:8];
  assign req_pix    = in_tdata[23:16];
  assign req_inside = (SW'(req_row) < h_sat) && (SW'(req_col) < w_sat);
  assign req_addr   = AW'(req_row * MAX_WIDTH + req_col);

  // sequencer registers
  state_t        state_r, state_nxt;
  logic [DW-1:0] r_r, r_nxt;
  logic [DW-1:0] c_r, c_nxt;
  logic [3:0]    k_r, k_nxt;
  logic          phase_r, phase_nxt;
  logic          changed_r, changed_nxt;
  logic [15:0]   passes_r, passes_nxt;
  logic          rd_pend_r;
  logic [3:0]    rd_k_r;
  logic [8:0]    nb_r;
  logic          rd_inside_r, rd_inside_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_pix_r, out_pix_nxt;
  logic [15:0]   out_pass_r, out_pass_nxt;

  // neighbour position for the gather step
  logic [DW-1:0] nr;
  logic [DW-1:0] nc;
  logic [AW-1:0] nb_addr;
  logic [AW-1:0] base_addr;

  always_comb begin
    nr = r_r;
    nc = c_r;
    case (k_r)
      4'd1: begin nr = r_r - 1'b1; end
      4'd2: begin nr = r_r - 1'b1; nc = c_r + 1'b1; end
      4'd3: begin nc = c_r + 1'b1; end
      4'd4: begin nr = r_r + 1'b1; nc = c_r + 1'b1; end
      4'd5: begin nr = r_r + 1'b1; end
      4'd6: begin nr = r_r + 1'b1; nc = c_r - 1'b1; end
      4'd7: begin nc = c_r - 1'b1; end
      4'd8: begin nr = r_r - 1'b1; nc = c_r - 1'b1; end
      default: ;
    endcase
  end

  assign nb_addr   = AW'(nr * MAX_WIDTH + nc);
  assign base_addr = AW'(r_r * MAX_WIDTH + c_r);

  // memories
  logic          img_we;
  logic [AW-1:0] img_waddr;
  logic          img_wdata;
  logic [AW-1:0] img_raddr;
  logic          img_rdata;
  logic          mk_we;
  logic          mk_wdata;
  logic          mk_rdata;
  logic          rule_mark;

  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marker (
    .clk   (clk),
    .we    (mk_we),
    .waddr (base_addr),
    .wdata (mk_wdata),
    .raddr (base_addr),
    .rdata (mk_rdata)
  );

  // shared rule unit
  bthin_rule u_rule (
    .center (nb_r[0]),
    .nb     (nb_r[8:1]),
    .phase  (phase_r),
    .mark   (rule_mark)
  );

  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  // end of a sweep over the interior
  logic last_col;
  logic last_px;
  assign last_col = (SW'(c_r) == w_sat - SW'(2));
  assign last_px  = last_col && (SW'(r_r) == h_sat - SW'(2));

  // memory port selection
  always_comb begin
    img_raddr = (state_r == ST_IDLE) ? req_addr : nb_addr;
    img_we    = 1'b0;
    img_waddr = base_addr;
    img_wdata = 1'b0;
    if (in_acc && (in_tuser == REQ_LOAD) && req_inside) begin
      img_we    = 1'b1;
      img_waddr = req_addr;
      img_wdata = (req_pix > thresh_r);
    end else if ((state_r == ST_CLR_WAIT) && mk_rdata) begin
      img_we = 1'b1;
    end
    mk_we    = (state_r == ST_MARK_EVAL);
    mk_wdata = rule_mark;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    phase_nxt     = phase_r;
    changed_nxt   = changed_r;
    passes_nxt    = passes_r;
    rd_inside_nxt = rd_inside_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pix_nxt   = out_pix_r;
    out_pass_nxt  = out_pass_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            REQ_RUN: begin
              passes_nxt  = '0;
              changed_nxt = 1'b0;
              phase_nxt   = 1'b0;
              r_nxt       = DW'(1);
              c_nxt       = DW'(1);
              k_nxt       = '0;
              state_nxt   = ST_MARK;
            end
            REQ_READ: begin
              rd_inside_nxt = req_inside;
              state_nxt     = ST_RD_WAIT;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_pix_nxt   = PIXEL_BG;
              out_pass_nxt  = passes_r;
            end
          endcase
        end
      end
      ST_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = (rd_inside_r && img_rdata) ? PIXEL_FG : PIXEL_BG;
        out_pass_nxt  = passes_r;
        state_nxt     = ST_IDLE;
      end
      ST_MARK: begin
        k_nxt = k_r + 4'd1;
        if (k_r == NB_LAST) begin
          state_nxt = ST_MARK_WAIT;
        end
      end
      ST_MARK_WAIT: begin
        state_nxt = ST_MARK_EVAL;
      end
      ST_MARK_EVAL: begin
        k_nxt = '0;
        if (last_px) begin
          r_nxt     = DW'(1);
          c_nxt     = DW'(1);
          state_nxt = ST_CLR;
        end else begin
          if (last_col) begin
            c_nxt = DW'(1);
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
          state_nxt = ST_MARK;
        end
      end
      ST_CLR: begin
        state_nxt = ST_CLR_WAIT;
      end
      ST_CLR_WAIT: begin
        if (mk_rdata) begin
          changed_nxt = 1'b1;
        end
        if (last_px) begin
          r_nxt     = DW'(1);
          c_nxt     = DW'(1);
          state_nxt = phase_r ? ST_PAIR_END : ST_MARK;
          phase_nxt = 1'b1;
        end else begin
          if (last_col) begin
            c_nxt = DW'(1);
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
          state_nxt = ST_CLR;
        end
      end
      ST_PAIR_END: begin
        if (passes_r != PASS_MAX) begin
          passes_nxt = passes_r + 16'd1;
        end
        phase_nxt   = 1'b0;
        changed_nxt = 1'b0;
        state_nxt   = changed_r ? ST_MARK : ST_DONE;
      end
      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_pix_nxt   = PIXEL_BG;
        out_pass_nxt  = passes_r;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      passes_r    <= '0;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      passes_r    <= passes_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= (state_r == ST_MARK);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r_r         <= r_nxt;
    c_r         <= c_nxt;
    k_r         <= k_nxt;
    phase_r     <= phase_nxt;
    changed_r   <= changed_nxt;
    rd_inside_r <= rd_inside_nxt;
    out_pix_r   <= out_pix_nxt;
    out_pass_r  <= out_pass_nxt;
    rd_k_r      <= k_r;
    if (rd_pend_r) begin
      nb_r[rd_k_r] <= img_rdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pass_r, out_pix_r};

  // checks
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == ST_IDLE))
    else $error("request taken while the sequencer is busy");

  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (passes_r != 16'd0))
    else $error("run finished without counting a pass pair");

  a_no_clear_in_mark: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_MARK) || (state_r == ST_MARK_EVAL)) |-> !img_we)
    else $error("image written during the marking sweep");

  a_gather_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK_EVAL) |-> $past(state_r == ST_MARK_WAIT))
    else $error("rule evaluated before all neighbours arrived");

endmodule

>>> tb/tb_binary_image_thinning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_image_thinning_core
// Loads thresholded images, runs Zhang-Suen thinning and reads pixels back,
// comparing every result with a skeleton predictor held in a scoreboard.
// ----------------------------------------------------------------------------
module tb_binary_image_thinning_core
  import bthin_pkg::*;
();

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int STALL_LIMIT = 500000;

  // expected result of one request
  typedef struct packed {
    logic [15:0] passes;
    logic [7:0]  pixel;
  } skel_result_t;

  // skeleton predictor and store of expected results
  class skel_scoreboard;
    bit           img [0:65535];
    bit           mark [0:65535];
    int unsigned  width_reg = SIZE_RESET, height_reg = SIZE_RESET;
    int unsigned  thresh = THRESHOLD_RESET;
    int unsigned  passes;
    skel_result_t pending_q[$];
    int           errors;

    function int unsigned clamp(int unsigned v);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > 256) return 256;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        CFG_IMAGE_WIDTH:  width_reg = val;
        CFG_IMAGE_HEIGHT: height_reg = val;
        CFG_THRESHOLD:    thresh = val[7:0];
        default: ;
      endcase
    endfunction

    function bit px(int r, int c);
      return img[r * 256 + c];
    endfunction

    // one sub-pass, returns the number of pixels cleared
    function int sweep(int w, int h, bit second);
      bit n [0:7];
      int a, b, cnt;
      bit m1, m2;
      cnt = 0;
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) mark[r * 256 + c] = 0;
      for (int r = 1; r + 1 < h; r++) begin
        for (int c = 1; c + 1 < w; c++) begin
          if (!px(r, c)) continue;
          n[0] = px(r - 1, c);     n[1] = px(r - 1, c + 1);
          n[2] = px(r, c + 1);     n[3] = px(r + 1, c + 1);
          n[4] = px(r + 1, c);     n[5] = px(r + 1, c - 1);
          n[6] = px(r, c - 1);     n[7] = px(r - 1, c - 1);
          a = 0; b = 0;
          for (int k = 0; k < 8; k++) begin
            b += n[k];
            if (!n[k] && n[(k + 1) % 8]) a++;
          end
          if (!second) begin
            m1 = n[0] & n[2] & n[4];
            m2 = n[2] & n[4] & n[6];
          end else begin
            m1 = n[0] & n[2] & n[6];
            m2 = n[0] & n[4] & n[6];
          end
          if (a == 1 && b >= NB_MIN && b <= NB_MAX && !m1 && !m2)
            mark[r * 256 + c] = 1;
        end
      end
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          if (mark[r * 256 + c] && img[r * 256 + c]) begin
            img[r * 256 + c] = 0;
            cnt++;
          end
      return cnt;
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] row, logic [7:0] col,
                               logic [7:0] grey);
      int unsigned w, h;
      int changed;
      bit in_image;
      skel_result_t res;
      w = clamp(width_reg);
      h = clamp(height_reg);
      in_image = row < h && col < w;
      res.pixel = PIXEL_BG;
      case (kind)
        REQ_LOAD: if (in_image) img[row * 256 + col] = grey > thresh;
        REQ_RUN: begin
          passes = 0;
          do begin
            changed = sweep(w, h, 0);
            changed += sweep(w, h, 1);
            if (passes < PASS_MAX) passes++;
          end while (changed != 0);
        end
        REQ_READ: if (in_image && px(row, col)) res.pixel = PIXEL_FG;
        default: ;
      endcase
      res.passes = 16'(passes);
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [23:0] data);
      skel_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (data[7:0] !== want.pixel) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, want.pixel, data[7:0]);
        errors++;
      end
      if (data[23:8] !== want.passes) begin
        $display("%0t: pass_count expected %0d actual %0d", $time, want.passes,
                 data[23:8]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_data = '0;

  skel_scoreboard sb = new();
  bit steady;
  int accepted_reqs;
  int quiet_cycles;

  always #6 clk = ~clk;

  binary_image_thinning_core dut (.*);

  // result sink, random backpressure and stall watchdog
  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= steady || ($urandom_range(0, 99) >= 31);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** binary_image_thinning_core: FAILED **");
      $finish;
    end
  end

  task automatic send_req(logic [1:0] kind, logic [7:0] row, logic [7:0] col,
                          logic [7:0] grey);
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= {grey, col, row};
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, row, col, grey);
    accepted_reqs++;
  endtask

  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // grey level on the requested side of the threshold (background when it is 255)
  function automatic logic [7:0] grey_for(bit fg);
    if (fg && sb.thresh < 255) return 8'($urandom_range(sb.thresh + 1, 255));
    return 8'($urandom_range(0, sb.thresh));
  endfunction

  // fills the whole image with one solid block, one full row and one full column, plus noise
  task automatic load_shapes(int w, int h);
    int r0, r1, c0, c1, r2, c2;
    bit fg;
    r0 = $urandom_range(0, h - 1); r1 = $urandom_range(r0, h - 1);
    c0 = $urandom_range(0, w - 1); c1 = $urandom_range(c0, w - 1);
    r2 = $urandom_range(0, h - 1); c2 = $urandom_range(0, w - 1);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        fg = (r >= r0 && r <= r1 && c >= c0 && c <= c1) || r == r2 || c == c2;
        if ($urandom_range(0, 9) == 0) fg = !fg;
        send_req(REQ_LOAD, 8'(r), 8'(c), grey_for(fg));
      end
  endtask

  task automatic random_phase();
    int w, h, n;
    logic [7:0] row, col;
    logic [1:0] kind;
    w = $urandom_range(0, 5) == 0 ? $urandom_range(17, 40) : $urandom_range(4, 16);
    h = w > 16 ? $urandom_range(4, 6) : $urandom_range(4, 16);
    write_cfg(CFG_IMAGE_WIDTH, 9'(w));
    write_cfg(CFG_IMAGE_HEIGHT, 9'(h));
    write_cfg(CFG_THRESHOLD, 9'($urandom_range(0, 255)));
    load_shapes(w, h);
    n = $urandom_range(20, 60);
    for (int i = 0; i < n; i++) begin
      row = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, h - 1));
      col = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, w - 1));
      case ($urandom_range(0, 19))
        0, 1, 2: kind = REQ_RUN;
        3, 4:    kind = REQ_LOAD;
        5:       kind = REQ_UNKNOWN;
        default: kind = REQ_READ;
      endcase
      if (i == n / 2 && $urandom_range(0, 1)) drain();
      send_req(kind, row, col, 8'($urandom));
    end
  endtask

  // full-size image: loads and read-backs across the whole address range
  task automatic wide_phase();
    logic [7:0] rows[$], cols[$];
    write_cfg(CFG_IMAGE_WIDTH, $urandom_range(0, 1) ? 9'd256 : 9'h1FF);
    write_cfg(CFG_IMAGE_HEIGHT, 9'($urandom_range(257, 511)));
    write_cfg(CFG_THRESHOLD, 9'($urandom_range(0, 255)));
    for (int i = 0; i < 30; i++) begin
      rows.push_back(8'($urandom)); cols.push_back(8'($urandom));
      send_req(REQ_LOAD, rows[i], cols[i], 8'($urandom));
    end
    for (int i = 0; i < 30; i++) send_req(REQ_READ, rows[i], cols[i], 8'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset sizes, corners and threshold edge
    send_req(REQ_LOAD, 8'd0, 8'd0, 8'd255);
    send_req(REQ_LOAD, 8'd255, 8'd255, 8'd11);
    send_req(REQ_LOAD, 8'd255, 8'd0, 8'd10);
    send_req(REQ_LOAD, 8'd0, 8'd255, 8'd0);
    send_req(REQ_READ, 8'd0, 8'd0, 8'd0);
    send_req(REQ_READ, 8'd255, 8'd255, 8'd255);
    send_req(REQ_READ, 8'd255, 8'd0, 8'd0);
    send_req(REQ_READ, 8'd0, 8'd255, 8'd0);
    send_req(REQ_UNKNOWN, 8'd255, 8'd255, 8'd255);
    drain();

    // sizes below the minimum saturate to four, zero threshold
    write_cfg(CFG_IMAGE_WIDTH, 9'd3);
    write_cfg(CFG_IMAGE_HEIGHT, 9'd0);
    write_cfg(CFG_THRESHOLD, 9'd0);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++)
        send_req(REQ_LOAD, 8'(r), 8'(c), (r + c) % 3 == 0 ? 8'd0 : 8'd1);
    send_req(REQ_READ, 8'd4, 8'd200, 8'd0);
    send_req(REQ_RUN, 8'd0, 8'd0, 8'd0);
    send_req(REQ_READ, 8'd1, 8'd2, 8'd0);
    send_req(REQ_LOAD, 8'd3, 8'd4, 8'd255);
    drain();

    // empty image under the maximum threshold
    write_cfg(CFG_THRESHOLD, 9'd255);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) send_req(REQ_LOAD, 8'(r), 8'(c), 8'd255);
    send_req(REQ_RUN, 8'd0, 8'd0, 8'd0);
    drain();

    // random phases, those begun before 200 accepted requests and about one in eight others free of idling
    while (accepted_reqs < 1900) begin
      steady = (accepted_reqs < 200) || ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) wide_phase();
      else random_phase();
      drain();
      steady = 0;
    end

    in_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("** binary_image_thinning_core: PASSED **");
    else
      $display("** binary_image_thinning_core: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
rtl/bthin_pkg.sv
rtl/bthin_ram.sv
rtl/bthin_rule.sv
rtl/binary_image_thinning_core.sv
tb/tb_binary_image_thinning_core.sv
